### hdl/swac_pkg.sv
// Shared types and constants for the sliding window alarm counter.
// Holds the beat structs, window sizing, register map and reset values.
// No dependencies.
package swac_pkg;

  localparam int unsigned WINDOW_LEN = 5;
  localparam int unsigned HIST_LEN   = WINDOW_LEN - 1;
  localparam int unsigned READ_W     = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned FILL_W     = $clog2(HIST_LEN + 1);
  localparam int unsigned ELEV_W     = $clog2(WINDOW_LEN + 1);
  localparam int unsigned MINEL_W    = 3;
  localparam int unsigned AVG_W      = 15;
  localparam int unsigned CMP_W      = (ELEV_W > MINEL_W) ? ELEV_W : MINEL_W;
  // Window sum plus headroom for the signed compare against the average limit
  localparam int unsigned SUM_W      = READ_W + $clog2(WINDOW_LEN) + 2;

  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic signed [READ_W-1:0]  OVER_LIMIT_RST  = 16'sd150;
  localparam logic signed [READ_W-1:0]  LEVEL_THRES_RST = 16'sd70;
  localparam logic        [MINEL_W-1:0] MIN_ELEV_RST    = 3'd3;
  localparam logic        [AVG_W-1:0]   AVG_LIMIT_RST   = 15'd90;
  localparam logic        [COUNT_W-1:0] COUNT_MAX       = '1;

  typedef enum logic [1:0] {
    REG_OVER_LIMIT   = 2'd0,
    REG_LEVEL_THRES  = 2'd1,
    REG_MIN_ELEVATED = 2'd2,
    REG_AVG_LIMIT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [READ_W-1:0] reading;
    logic                     last_reading;
  } in_beat_t;

  typedef struct packed {
    logic               window_ready;
    logic               critical;
    logic [COUNT_W-1:0] critical_count;
    logic               sequence_done;
  } out_beat_t;

endpackage

### hdl/sliding_window_alarm_counter.sv
// Sliding window alarm counter: judges each five-reading window of a sensor stream.
// Depends on swac_pkg for beat types, window sizing and the register map.
//
//  channel  | direction | handshake                | beat
//  ---------+-----------+--------------------------+---------------------------
//  in       | sink      | in_valid_i / in_stall_o  | swac_pkg::in_beat_t
//  out      | source    | out_valid_o / out_stall_i| swac_pkg::out_beat_t
//  config   | APB slave | psel/penable/pwrite      | 32-bit registers at 4*i
//
// One beat is taken every cycle while the result register can move on; an accepted
// beat passes the input register, then judge logic into the result register.
// The history update sits on the single judge stage, so consecutive beats see each
// other's readings with no bubble.
// Reset clears the history, fill level, tally and both stage valids, and loads
// the register reset values. A stalled output holds its beat; the input stage
// keeps accepting as long as the result register can move on.
module sliding_window_alarm_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  swac_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output swac_pkg::out_beat_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swac_pkg::PADDR_W-1:0]        paddr,
  input  logic [swac_pkg::PDATA_W-1:0]        pwdata,
  output logic [swac_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [swac_pkg::READ_W-1:0]  over_limit_q;
  logic signed [swac_pkg::READ_W-1:0]  level_thres_q;
  logic        [swac_pkg::MINEL_W-1:0] min_elev_q;
  logic        [swac_pkg::AVG_W-1:0]   avg_limit_q;
  logic                                cfg_wr;
  swac_pkg::cfg_reg_e                  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  // word address: drop the byte offset
  assign cfg_sel = swac_pkg::cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_limit_q  <= swac_pkg::OVER_LIMIT_RST;
      level_thres_q <= swac_pkg::LEVEL_THRES_RST;
      min_elev_q    <= swac_pkg::MIN_ELEV_RST;
      avg_limit_q   <= swac_pkg::AVG_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        swac_pkg::REG_OVER_LIMIT:   over_limit_q  <= pwdata[swac_pkg::READ_W-1:0];
        swac_pkg::REG_LEVEL_THRES:  level_thres_q <= pwdata[swac_pkg::READ_W-1:0];
        swac_pkg::REG_MIN_ELEVATED: min_elev_q    <= pwdata[swac_pkg::MINEL_W-1:0];
        swac_pkg::REG_AVG_LIMIT:    avg_limit_q   <= pwdata[swac_pkg::AVG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      swac_pkg::REG_OVER_LIMIT:
        prdata = {{(swac_pkg::PDATA_W-swac_pkg::READ_W){over_limit_q[swac_pkg::READ_W-1]}},
                  over_limit_q};
      swac_pkg::REG_LEVEL_THRES:
        prdata = {{(swac_pkg::PDATA_W-swac_pkg::READ_W){level_thres_q[swac_pkg::READ_W-1]}},
                  level_thres_q};
      swac_pkg::REG_MIN_ELEVATED:
        prdata = {{(swac_pkg::PDATA_W-swac_pkg::MINEL_W){1'b0}}, min_elev_q};
      swac_pkg::REG_AVG_LIMIT:
        prdata = {{(swac_pkg::PDATA_W-swac_pkg::AVG_W){1'b0}}, avg_limit_q};
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: input register feeds the judge stage, which loads the
  // result register. Advance whenever the result register is free or drained.
  // ---------------------------------------------------------------------------
  logic                s1_valid_q;
  swac_pkg::in_beat_t  s1_data_q;
  logic                out_valid_q;
  swac_pkg::out_beat_t out_data_q;
  logic                s1_adv;
  logic                s1_fire;
  logic                in_take;

  assign s1_adv      = ~out_valid_q | ~out_stall_i;
  assign s1_fire     = s1_valid_q & s1_adv;
  assign in_stall_o  = s1_valid_q & ~s1_adv;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (~s1_valid_q | s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload: load only on a taken beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Window state. The history shifts in the newest reading, except that the last
  // reading of a sequence clears it; a window is judged only once the fill level
  // says every slot holds a real reading, so zeros pushed out while filling never matter.
  // ---------------------------------------------------------------------------
  logic signed [swac_pkg::READ_W-1:0]  hist_q [swac_pkg::HIST_LEN];
  logic        [swac_pkg::FILL_W-1:0]  fill_q;
  logic        [swac_pkg::COUNT_W-1:0] tally_q;

  logic                                full;
  logic signed [swac_pkg::SUM_W-1:0]   sum_w;
  logic        [swac_pkg::ELEV_W-1:0]  elev_w;
  logic                                over_w;
  logic        [swac_pkg::SUM_W-1:0]   lim_w;
  logic                                crit_w;
  logic        [swac_pkg::COUNT_W-1:0] tally_d;
  logic signed [swac_pkg::READ_W-1:0]  newest;

  assign newest = s1_data_q.reading;
  assign full   = (fill_q >= swac_pkg::FILL_W'(swac_pkg::HIST_LEN));

  // Sum, elevated count and over-limit flag across the window
  always_comb begin
    sum_w  = {{(swac_pkg::SUM_W-swac_pkg::READ_W){newest[swac_pkg::READ_W-1]}}, newest};
    elev_w = swac_pkg::ELEV_W'(newest >= level_thres_q);
    over_w = (newest > over_limit_q);
    for (int i = 0; i < swac_pkg::HIST_LEN; i++) begin
      sum_w  = sum_w + {{(swac_pkg::SUM_W-swac_pkg::READ_W){hist_q[i][swac_pkg::READ_W-1]}},
                        hist_q[i]};
      elev_w = elev_w + swac_pkg::ELEV_W'(hist_q[i] >= level_thres_q);
      over_w = over_w | (hist_q[i] > over_limit_q);
    end
  end

  // Truncated average above the limit, done exactly as sum >= N*(limit+1)
  assign lim_w  = (swac_pkg::SUM_W'(avg_limit_q) + swac_pkg::SUM_W'(1))
                * swac_pkg::SUM_W'(swac_pkg::WINDOW_LEN);
  assign crit_w = full & ~over_w
                & (swac_pkg::CMP_W'(elev_w) >= swac_pkg::CMP_W'(min_elev_q))
                & ($signed(sum_w) >= $signed(lim_w));

  // Saturating tally
  assign tally_d = (crit_w && (tally_q != swac_pkg::COUNT_MAX))
                 ? tally_q + swac_pkg::COUNT_W'(1) : tally_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < swac_pkg::HIST_LEN; i++) begin
        hist_q[i] <= '0;
      end
      fill_q  <= '0;
      tally_q <= '0;
    end else if (s1_fire) begin
      if (s1_data_q.last_reading) begin
        // sequence ends: drop the window and restart the count
        for (int i = 0; i < swac_pkg::HIST_LEN; i++) begin
          hist_q[i] <= '0;
        end
        fill_q  <= '0;
        tally_q <= '0;
      end else begin
        for (int i = 0; i + 1 < swac_pkg::HIST_LEN; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[swac_pkg::HIST_LEN-1] <= newest;
        fill_q  <= full ? fill_q : fill_q + swac_pkg::FILL_W'(1);
        tally_q <= tally_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q.window_ready   <= full;
      out_data_q.critical       <= crit_w;
      out_data_q.critical_count <= tally_d;
      out_data_q.sequence_done  <= s1_data_q.last_reading;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= swac_pkg::FILL_W'(swac_pkg::HIST_LEN))
    else $error("fill level beyond history depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_data_q.last_reading) |=> (fill_q == '0 && tally_q == '0))
    else $error("window state not cleared after last reading");

  a_crit_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.critical) |->
      (out_data_o.window_ready && out_data_o.critical_count != '0))
    else $error("critical result without full window or count");

  a_no_fire_when_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(tally_q) && $stable(fill_q))
    else $error("window state moved while result stalled");

endmodule
